### sv/smeval_pkg.sv
// ----------------------------------------------------------------------------
// smeval_pkg
// Shared types and constants of the stack machine evaluator.
// ----------------------------------------------------------------------------
package smeval_pkg;

	localparam int unsigned STACK_DEPTH = 256;
	localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
	localparam int unsigned DATA_W      = 64;
	localparam int unsigned DEPTH_W     = 9;

	typedef logic [SP_W-1:0]   sp_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [3:0] {
		OP_CONST = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_MAX   = 4'd5,
		OP_MIN   = 4'd6,
		OP_NEG   = 4'd7,
		OP_DUP   = 4'd8,
		OP_SWAP  = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXEC,
		CS_MULDIV
	} ctl_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_SIGN
	} md_state_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

endpackage

### sv/smeval_if.sv
// ----------------------------------------------------------------------------
// smeval_if
// Valid/ready channels: instruction word in, result word out.
// ----------------------------------------------------------------------------
interface smeval_instr_if;
	logic               valid;
	logic               ready;
	logic [3:0]         op;
	logic signed [63:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface smeval_result_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] top_value;
	logic [8:0]         depth;
	logic [1:0]         status;

	modport source (output valid, output top_value, output depth, output status, input ready);
	modport sink   (input valid, input top_value, input depth, input status, output ready);
endinterface

### sv/smeval_ram.sv
// ----------------------------------------------------------------------------
// smeval_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smeval_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/smeval_muldiv.sv
// ----------------------------------------------------------------------------
// smeval_muldiv
// Multicycle 64-bit multiply (low half, three 32x32 partial products) and
// truncating signed divide (restoring, one quotient bit per cycle).
// ----------------------------------------------------------------------------
module smeval_muldiv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  smeval_pkg::md_req_t   req,
	input  logic signed [63:0]    a,
	input  logic signed [63:0]    b,
	output logic                  done,
	output logic [63:0]           result
);

	smeval_pkg::md_state_t state_q, state_d;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [63:0] a_q, b_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [63:0] quo_q;
	logic [64:0] rem_q;
	logic        neg_q;

	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [64:0] shifted;
	logic [65:0] diff;

	// partial product select: lo*lo, lo*hi, hi*lo
	always_comb begin
		pa = a_q[31:0];
		pb = b_q[31:0];
		case (cnt_q[1:0])
			2'd1: pb = b_q[63:32];
			2'd2: pa = a_q[63:32];
			default: ;
		endcase
	end

	assign pp      = pa * pb;
	assign shifted = {rem_q[63:0], quo_q[63]};
	assign diff    = {1'b0, shifted} - {2'b00, b_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smeval_pkg::MD_IDLE: begin
				if (req.start) begin
					state_d = req.is_div ? smeval_pkg::MD_DIV : smeval_pkg::MD_MUL;
				end
			end
			smeval_pkg::MD_MUL: begin
				if (cnt_q == 6'd3) begin
					state_d = smeval_pkg::MD_IDLE;
				end
			end
			smeval_pkg::MD_DIV: begin
				if (cnt_q == 6'd63) begin
					state_d = smeval_pkg::MD_SIGN;
				end
			end
			smeval_pkg::MD_SIGN: state_d = smeval_pkg::MD_IDLE;
			default: state_d = smeval_pkg::MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smeval_pkg::MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req.start && state_q == smeval_pkg::MD_IDLE) begin
				cnt_q  <= '0;
				done_q <= 1'b0;
			end else if (state_q == smeval_pkg::MD_MUL || state_q == smeval_pkg::MD_DIV) begin
				cnt_q <= cnt_q + 6'd1;
				if (state_q == smeval_pkg::MD_MUL && cnt_q == 6'd3) begin
					done_q <= 1'b1;
				end
			end else if (state_q == smeval_pkg::MD_SIGN) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && state_q == smeval_pkg::MD_IDLE) begin
			if (req.is_div) begin
				// divide on magnitudes, fix the sign at the end
				a_q   <= 64'd0;
				b_q   <= b[63] ? (64'd0 - b) : b;
				quo_q <= a[63] ? (64'd0 - a) : a;
				rem_q <= '0;
				neg_q <= a[63] ^ b[63];
			end else begin
				a_q <= a;
				b_q <= b;
			end
		end else begin
			unique case (state_q)
				smeval_pkg::MD_MUL: begin
					prod_q <= pp;
					case (cnt_q[1:0])
						2'd1: acc_q <= prod_q;
						2'd2, 2'd3: acc_q <= acc_q + {prod_q[31:0], 32'd0};
						default: ;
					endcase
				end
				smeval_pkg::MD_DIV: begin
					if (!diff[65]) begin
						rem_q <= diff[64:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= shifted;
						quo_q <= {quo_q[62:0], 1'b0};
					end
				end
				smeval_pkg::MD_SIGN: begin
					acc_q <= neg_q ? (64'd0 - quo_q) : quo_q;
				end
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

### sv/stack_machine_evaluator.sv
// ----------------------------------------------------------------------------
// stack_machine_evaluator
// Executes one stack instruction per word on a 64-bit signed operand stack.
// ----------------------------------------------------------------------------
// Usage:
//   instr  : sink channel, one instruction word (op, value) per handshake.
//   result : source channel, one word (top_value, depth, status) per
//            instruction, in order.
//   The top of stack lives in a register; the entries below it live in a
//   synchronous RAM with one write and one read port, read as an
//   instruction is accepted. Each instruction is accepted with its RAM read,
//   then executed and written back before the next is accepted. MUL uses
//   three 32x32 partial products through one multiplier, DIV a 64-step
//   restoring divider plus sign fix-up.
//   The result register holds one word; a new instruction is accepted while
//   it waits, but the next result is not written back until the receiver
//   takes the pending one, so a stalled receiver stalls the stack.
//   Reset: the stack is empty (depth 0); RAM contents are left as they are,
//   and entries not yet written may be read but their data is never used.
//   Underflow, overflow and divide by zero leave the stack unchanged and
//   report a status code.
// ----------------------------------------------------------------------------
module stack_machine_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	smeval_instr_if.sink       instr,
	smeval_result_if.source    result
);

	smeval_pkg::ctl_state_t state_q, state_d;
	smeval_pkg::sp_t        sp_q, sp_c, sp_m1, sp_m2;
	smeval_pkg::op_t        op_q;
	logic signed [63:0]     val_q;
	logic signed [63:0]     tos_q, tos_c;
	logic signed [63:0]     rd_data;
	logic signed [63:0]     alu_r;
	logic [63:0]            md_result;
	logic                   md_done;
	smeval_pkg::md_req_t    md_req;

	logic                   result_valid_q;
	logic signed [63:0]     top_q;
	logic [8:0]             depth_q;
	smeval_pkg::status_t    status_q, status_c;

	logic                   rd_en;
	logic                   we_c, ram_we;
	smeval_pkg::addr_t      waddr_c;
	logic                   need_md;
	logic                   commit;
	logic                   slot_free;
	logic                   empty, under2, full;

	assign sp_m1  = sp_q - smeval_pkg::sp_t'(1);
	assign sp_m2  = sp_q - smeval_pkg::sp_t'(2);
	assign empty  = (sp_q == '0);
	assign under2 = (sp_q < smeval_pkg::sp_t'(2));
	assign full   = (sp_q == smeval_pkg::sp_t'(smeval_pkg::STACK_DEPTH));

	assign instr.ready = (state_q == smeval_pkg::CS_IDLE);
	assign rd_en       = instr.valid && instr.ready;
	assign slot_free   = !result_valid_q || result.ready;
	assign ram_we      = commit && we_c;

	// entries below the top of stack
	smeval_ram #(
		.DEPTH (smeval_pkg::STACK_DEPTH),
		.WIDTH (smeval_pkg::DATA_W)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_c),
		.wdata (tos_q),
		.re    (rd_en),
		.raddr (sp_m2[smeval_pkg::ADDR_W-1:0]),
		.rdata (rd_data)
	);

	smeval_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (tos_q),
		.b      (rd_data),
		.done   (md_done),
		.result (md_result)
	);

	always_comb begin
		case (op_q) inside
			smeval_pkg::OP_ADD: alu_r = tos_q + rd_data;
			smeval_pkg::OP_SUB: alu_r = tos_q - rd_data;
			smeval_pkg::OP_MAX: alu_r = (rd_data < tos_q) ? tos_q : rd_data;
			smeval_pkg::OP_MIN: alu_r = (tos_q < rd_data) ? tos_q : rd_data;
			default:            alu_r = md_result;
		endcase
	end

	// outcome of the latched instruction
	always_comb begin
		status_c = smeval_pkg::ST_OK;
		sp_c     = sp_q;
		tos_c    = tos_q;
		we_c     = 1'b0;
		waddr_c  = sp_m1[smeval_pkg::ADDR_W-1:0];
		need_md  = 1'b0;
		case (op_q) inside
			smeval_pkg::OP_CONST: begin
				if (full) begin
					status_c = smeval_pkg::ST_OVER;
				end else begin
					we_c  = !empty;
					tos_c = val_q;
					sp_c  = sp_q + smeval_pkg::sp_t'(1);
				end
			end
			smeval_pkg::OP_ADD, smeval_pkg::OP_SUB, smeval_pkg::OP_MUL,
			smeval_pkg::OP_DIV, smeval_pkg::OP_MAX, smeval_pkg::OP_MIN: begin
				if (under2) begin
					status_c = smeval_pkg::ST_UNDER;
				end else if (op_q == smeval_pkg::OP_DIV && rd_data == '0) begin
					status_c = smeval_pkg::ST_DIVZ;
				end else begin
					tos_c   = alu_r;
					sp_c    = sp_m1;
					need_md = (op_q == smeval_pkg::OP_MUL) || (op_q == smeval_pkg::OP_DIV);
				end
			end
			smeval_pkg::OP_SWAP: begin
				if (under2) begin
					status_c = smeval_pkg::ST_UNDER;
				end else begin
					tos_c   = rd_data;
					we_c    = 1'b1;
					waddr_c = sp_m2[smeval_pkg::ADDR_W-1:0];
				end
			end
			smeval_pkg::OP_NEG: begin
				if (empty) begin
					status_c = smeval_pkg::ST_UNDER;
				end else begin
					tos_c = 64'sd0 - tos_q;
				end
			end
			smeval_pkg::OP_DUP: begin
				if (empty) begin
					status_c = smeval_pkg::ST_UNDER;
				end else if (full) begin
					status_c = smeval_pkg::ST_OVER;
				end else begin
					we_c = 1'b1;
					sp_c = sp_q + smeval_pkg::sp_t'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		commit  = 1'b0;
		md_req  = '0;
		unique case (state_q)
			smeval_pkg::CS_IDLE: begin
				if (rd_en) begin
					state_d = smeval_pkg::CS_EXEC;
				end
			end
			smeval_pkg::CS_EXEC: begin
				if (need_md) begin
					md_req.start  = 1'b1;
					md_req.is_div = (op_q == smeval_pkg::OP_DIV);
					state_d       = smeval_pkg::CS_MULDIV;
				end else if (slot_free) begin
					commit  = 1'b1;
					state_d = smeval_pkg::CS_IDLE;
				end
			end
			smeval_pkg::CS_MULDIV: begin
				if (md_done && slot_free) begin
					commit  = 1'b1;
					state_d = smeval_pkg::CS_IDLE;
				end
			end
			default: state_d = smeval_pkg::CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= smeval_pkg::CS_IDLE;
			sp_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				sp_q           <= sp_c;
				result_valid_q <= 1'b1;
			end else if (result.ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			op_q  <= smeval_pkg::op_t'(instr.op);
			val_q <= instr.value;
		end
		if (commit) begin
			tos_q    <= tos_c;
			top_q    <= (sp_c == '0) ? 64'sd0 : tos_c;
			depth_q  <= smeval_pkg::DEPTH_W'(sp_c);
			status_q <= status_c;
		end
	end

	assign result.valid     = result_valid_q;
	assign result.top_value = top_q;
	assign result.depth     = depth_q;
	assign result.status    = status_q;

endmodule
